// ----- rtl/dsg_pkg.sv -----
package dsg_pkg;

   // Operation codes of an input transaction
   typedef enum logic [2:0] {
      OP_SET    = 3'd0,
      OP_TOGGLE = 3'd1,
      OP_READ   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_RENDER = 3'd4
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MODIFY,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   // Result kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Register word index
   localparam logic REG_SWING = 1'b0;

   localparam logic [6:0] MAX_VEL       = 7'd127;
   localparam logic [6:0] TOGGLE_VEL    = 7'd100;
   localparam logic [8:0] SWING_MAX     = 9'd256;
   localparam logic [8:0] NOTE_LEN      = 9'd461;
   localparam logic [6:0] FALLBACK_NOTE = 7'd60;

   // General MIDI drum notes of the first eight instruments
   localparam logic [6:0] GM_NOTES [8] = '{
      7'd36, 7'd38, 7'd42, 7'd46, 7'd41, 7'd45, 7'd48, 7'd39
   };

   function automatic logic [6:0] note_of(input logic [4:0] idx);
      logic [6:0] note;
      if (idx < 5'd8) begin
         note = GM_NOTES[idx[2:0]];
      end else begin
         note = FALLBACK_NOTE;
      end
      return note;
   endfunction

endpackage

// ----- rtl/dsg_grid_ram.sv -----
module dsg_grid_ram #(
   parameter int ADDR_W = 7,
   parameter int DEPTH  = 128
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [6:0]        wdata,
   output logic [6:0]        rd_data
);

   logic [6:0] mem [DEPTH];
   logic [6:0] rd_data_ff;

   // Single port, read before write, registered read data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/drum_step_sequencer_grid_unit.sv -----
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------------------------------
// request   | start, busy           | req_op, req_step_index,
//           |                       | req_instrument_index, req_velocity_in
// response  | rsp_valid (1 cycle)   | rsp_kind, rsp_instrument_out, rsp_note_number,
//           |                       | rsp_velocity_out, rsp_start_pos,
//           |                       | rsp_note_length, rsp_last
// registers | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// Render reads one grid cell per cycle through the single RAM port.
// After reset the grid is swept to zero, one cell per cycle, with busy high until
// the last cell is written; register writes still work.
// Responses are shown for exactly one cycle; the receiver cannot stall them.
module drum_step_sequencer_grid_unit #(
   parameter int NUM_STEPS       = 16,
   parameter int NUM_INSTRUMENTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_step_index,
   input  logic [2:0]  req_instrument_index,
   input  logic [7:0]  req_velocity_in,
   // response channel
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [2:0]  rsp_instrument_out,
   output logic [6:0]  rsp_note_number,
   output logic [6:0]  rsp_velocity_out,
   output logic [12:0] rsp_start_pos,
   output logic [8:0]  rsp_note_length,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import dsg_pkg::*;

   localparam int STEP_AW = $clog2(NUM_STEPS);
   localparam int INST_AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
   localparam int ADDR_W  = STEP_AW + INST_AW;
   localparam int DEPTH   = NUM_STEPS * (2 ** INST_AW);

   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [INST_AW-1:0] LAST_INST = INST_AW'(NUM_INSTRUMENTS - 1);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [3:0]          step_ff, step_in;
   logic [2:0]          inst_ff, inst_in;
   logic [6:0]          vel_ff, vel_in;
   logic [INST_AW-1:0]  cnt_ff, cnt_in;
   logic [INST_AW-1:0]  cnt_d_ff, cnt_d_in;
   logic                scan_v_ff, scan_v_in;
   logic                pend_v_ff, pend_v_in;
   logic [INST_AW-1:0]  pend_inst_ff, pend_inst_in;
   logic [6:0]          pend_vel_ff, pend_vel_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [8:0]          swing_ff, swing_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [2:0]          rsp_inst_ff, rsp_inst_in;
   logic [6:0]          rsp_note_ff, rsp_note_in;
   logic [6:0]          rsp_vel_ff, rsp_vel_in;
   logic [12:0]         rsp_start_ff, rsp_start_in;
   logic [8:0]          rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [6:0]          mem_wdata;
   logic [6:0]          rd_data;

   logic                accept;
   logic                cell_ok;
   logic                step_ok;
   logic [STEP_AW-1:0]  step_a;
   logic [INST_AW-1:0]  inst_a;
   logic [12:0]         start_w;
   logic                csr_wr;
   logic [8:0]          wr_val;

   // Grid storage
   dsg_grid_ram #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_grid (
      .clock   (clock),
      .we      (mem_we),
      .addr    (mem_addr),
      .wdata   (mem_wdata),
      .rd_data (rd_data)
   );

   // Register port: swing saturates at 1.0
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SWING);
   assign wr_val = pwdata[8:0];
   assign swing_in = csr_wr ? ((wr_val > SWING_MAX) ? SWING_MAX : wr_val) : swing_ff;
   assign prdata = (paddr[2] == REG_SWING) ? {23'd0, swing_ff} : 32'd0;

   // Handshake
   assign busy   = (state_ff != ST_IDLE) | rsp_valid_ff;
   assign accept = start & ~busy;

   // Decoded cell of the latched transaction
   assign step_ok = int'(step_ff) < NUM_STEPS;
   assign cell_ok = step_ok && (int'(inst_ff) < NUM_INSTRUMENTS);
   assign step_a  = STEP_AW'(step_ff);
   assign inst_a  = INST_AW'(inst_ff);
   assign start_w = {step_ff, 9'd0} + (step_ff[0] ? 13'(swing_ff) : 13'd0);

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      inst_in      = inst_ff;
      vel_in       = vel_ff;
      cnt_in       = cnt_ff;
      cnt_d_in     = cnt_ff;
      scan_v_in    = 1'b0;
      pend_v_in    = pend_v_ff;
      pend_inst_in = pend_inst_ff;
      pend_vel_in  = pend_vel_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_addr     = {step_a, inst_a};
      mem_wdata    = 7'd0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;

      // Scan data: a new active cell pushes out the held event
      if (scan_v_ff && (rd_data != 7'd0)) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_EVENT;
            rsp_inst_in  = 3'(pend_inst_ff);
            rsp_note_in  = note_of(5'(pend_inst_ff));
            rsp_vel_in   = pend_vel_ff;
            rsp_start_in = start_w;
            rsp_len_in   = NOTE_LEN;
            rsp_last_in  = 1'b0;
         end
         pend_v_in    = 1'b1;
         pend_inst_in = cnt_d_ff;
         pend_vel_in  = rd_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 7'd0;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               step_in  = req_step_index;
               inst_in  = req_instrument_index;
               vel_in   = (req_velocity_in > 8'(MAX_VEL)) ? MAX_VEL : req_velocity_in[6:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_SET: begin
                  mem_we    = cell_ok;
                  mem_wdata = vel_ff;
                  state_in  = ST_IDLE;
               end
               OP_TOGGLE, OP_READ: begin
                  state_in = ST_MODIFY;
               end
               OP_CLEAR: begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end
               OP_RENDER: begin
                  cnt_in    = '0;
                  pend_v_in = 1'b0;
                  state_in  = step_ok ? ST_SCAN : ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MODIFY: begin
            if (op_ff == OP_READ) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_READ;
               rsp_inst_in  = inst_ff;
               rsp_note_in  = note_of({2'b00, inst_ff});
               rsp_vel_in   = cell_ok ? rd_data : 7'd0;
               rsp_start_in = 13'd0;
               rsp_len_in   = 9'd0;
               rsp_last_in  = 1'b1;
            end else begin
               mem_we    = cell_ok;
               mem_wdata = (rd_data != 7'd0) ? 7'd0 : TOGGLE_VEL;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            mem_addr  = {step_a, cnt_ff};
            scan_v_in = 1'b1;
            cnt_d_in  = cnt_ff;
            if (cnt_ff == LAST_INST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + INST_AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            // Held event is the last one of the step
            if (pend_v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EVENT;
               rsp_inst_in  = 3'(pend_inst_ff);
               rsp_note_in  = note_of(5'(pend_inst_ff));
               rsp_vel_in   = pend_vel_ff;
               rsp_start_in = start_w;
               rsp_len_in   = NOTE_LEN;
               rsp_last_in  = 1'b1;
            end
            pend_v_in = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_v_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         swing_ff     <= 9'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_v_ff    <= scan_v_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         swing_ff     <= swing_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      step_ff      <= step_in;
      inst_ff      <= inst_in;
      vel_ff       <= vel_in;
      cnt_ff       <= cnt_in;
      cnt_d_ff     <= cnt_d_in;
      pend_inst_ff <= pend_inst_in;
      pend_vel_ff  <= pend_vel_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_inst_ff  <= rsp_inst_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_instrument_out = rsp_inst_ff;
   assign rsp_note_number    = rsp_note_ff;
   assign rsp_velocity_out   = rsp_vel_ff;
   assign rsp_start_pos      = rsp_start_ff;
   assign rsp_note_length    = rsp_len_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ----- rtl/dsg_checker.sv -----
module dsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_kind,
   input logic [8:0]  rsp_note_length,
   input logic        rsp_last
);

   import dsg_pkg::*;

   // Grid sweep holds the request side off right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   // An accepted transaction keeps busy high on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted transaction");

   // Responses only appear while a transaction is in flight
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // A read reply is always the single, final response
   a_read_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_READ)) |-> rsp_last)
      else $error("read reply without last");

   // Note events carry the fixed length
   a_event_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_EVENT)) |-> (rsp_note_length == NOTE_LEN))
      else $error("note event with wrong length");

endmodule

bind drum_step_sequencer_grid_unit dsg_checker u_dsg_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_kind        (rsp_kind),
   .rsp_note_length (rsp_note_length),
   .rsp_last        (rsp_last)
);

// ----- tb/sv/drum_grid_tb_pkg.sv -----
`timescale 1ns / 100ps

package drum_grid_tb_pkg;

   import dsg_pkg::*;

   // Op codes the block ignores
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int GRID_STEPS = 16;
   localparam int GRID_ROWS  = 8;

   localparam logic [6:0] VEL_CEIL     = 7'd127;
   localparam logic [6:0] TOGGLE_LEVEL = 7'd100;
   localparam logic [8:0] SWING_CEIL   = 9'd256;
   localparam logic [8:0] EVENT_LEN    = 9'd461;

   // GM drum map: kick, snare, closed hat, open hat, low tom, mid tom, high tom, clap
   localparam logic [6:0] DRUM_NOTE [GRID_ROWS] = '{
      7'd36, 7'd38, 7'd42, 7'd46, 7'd41, 7'd45, 7'd48, 7'd39
   };

   typedef struct packed {
      logic        kind;
      logic [2:0]  inst;
      logic [6:0]  note;
      logic [6:0]  vel;
      logic [12:0] start_pos;
      logic [8:0]  len;
      logic        last;
   } grid_result_type;

   // Mirror of the pattern grid plus the queue of results it still owes
   class pattern_tracker;
      logic [6:0]      grid [GRID_STEPS][GRID_ROWS];
      logic [8:0]      swing;
      grid_result_type pending [$];
      int unsigned     errors;

      function new();
         wipe_grid();
         swing  = '0;
         errors = 0;
      endfunction

      function void wipe_grid();
         foreach (grid[s, i]) grid[s][i] = '0;
      endfunction

      function void write_swing(logic [31:0] value);
         logic [8:0] raw;
         raw   = value[8:0];
         swing = (raw > SWING_CEIL) ? SWING_CEIL : raw;
      endfunction

      // Apply one accepted command and queue what it should produce
      function void apply_command(logic [2:0] op, logic [3:0] step, logic [2:0] inst,
                                  logic [7:0] vel_in);
         grid_result_type item;
         logic [12:0]     base;
         int              last_row;
         case (op)
            OP_SET: begin
               grid[step][inst] = (vel_in > 8'(VEL_CEIL)) ? VEL_CEIL : vel_in[6:0];
            end
            OP_TOGGLE: begin
               grid[step][inst] = (grid[step][inst] != 0) ? 7'd0 : TOGGLE_LEVEL;
            end
            OP_READ: begin
               item.kind      = KIND_READ;
               item.inst      = inst;
               item.note      = DRUM_NOTE[inst];
               item.vel       = grid[step][inst];
               item.start_pos = '0;
               item.len       = '0;
               item.last      = 1'b1;
               pending = {pending, item};
            end
            OP_CLEAR: begin
               wipe_grid();
            end
            OP_RENDER: begin
               // step * 512, odd steps pushed late by the swing amount
               base = {step, 9'd0};
               if (step[0]) base = base + 13'(swing);
               last_row = -1;
               for (int i = 0; i < GRID_ROWS; i++)
                  if (grid[step][i] != 0) last_row = i;
               for (int i = 0; i < GRID_ROWS; i++) begin
                  if (grid[step][i] != 0) begin
                     item.kind      = KIND_EVENT;
                     item.inst      = 3'(i);
                     item.note      = DRUM_NOTE[i];
                     item.vel       = grid[step][i];
                     item.start_pos = base;
                     item.len       = EVENT_LEN;
                     item.last      = (i == last_row);
                     pending = {pending, item};
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Check one response against the oldest outstanding one
      function void match_result(grid_result_type got);
         grid_result_type want;
         if (pending.size() == 0) begin
            $error("response with nothing outstanding: kind %0d inst %0d vel %0d",
                   got.kind, got.inst, got.vel);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("kind",           want.kind,      got.kind);
         compare_field("instrument_out", want.inst,      got.inst);
         compare_field("note_number",    want.note,      got.note);
         compare_field("velocity_out",   want.vel,       got.vel);
         compare_field("start_pos",      want.start_pos, got.start_pos);
         compare_field("note_length",    want.len,       got.len);
         compare_field("last",           want.last,      got.last);
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   import dsg_pkg::*;
   import drum_grid_tb_pkg::*;

   // Longest busy stretch with no response (grid clear) plus margin
   localparam int QUIET_CYCLES = 150;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 67;
   localparam logic [2:0] SWING_ADDR = 3'(4 * REG_SWING);

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [3:0]  req_step_index;
   logic [2:0]  req_instrument_index;
   logic [7:0]  req_velocity_in;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [2:0]  rsp_instrument_out;
   logic [6:0]  rsp_note_number;
   logic [6:0]  rsp_velocity_out;
   logic [12:0] rsp_start_pos;
   logic [8:0]  rsp_note_length;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pattern_tracker tracker = new();
   bit no_gaps;

   drum_step_sequencer_grid_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_step_index       (req_step_index),
      .req_instrument_index (req_instrument_index),
      .req_velocity_in      (req_velocity_in),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_instrument_out   (rsp_instrument_out),
      .rsp_note_number      (rsp_note_number),
      .rsp_velocity_out     (rsp_velocity_out),
      .rsp_start_pos        (rsp_start_pos),
      .rsp_note_length      (rsp_note_length),
      .rsp_last             (rsp_last),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit, far beyond the slowest legal run
   initial begin
      #(4_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // Response monitor: a response is taken at the edge closing its cycle
   always @(posedge clock) begin : watch_responses
      grid_result_type seen;
      if (!reset && rsp_valid) begin
         seen.kind      = rsp_kind;
         seen.inst      = rsp_instrument_out;
         seen.note      = rsp_note_number;
         seen.vel       = rsp_velocity_out;
         seen.start_pos = rsp_start_pos;
         seen.len       = rsp_note_length;
         seen.last      = rsp_last;
         tracker.match_result(seen);
      end
   end

   // Register write: setup then access phase, done once pready is seen
   task automatic write_swing_reg(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SWING_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.write_swing(value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One command transaction; start stays high when no gap follows
   task automatic send_command(input logic [2:0] op, input logic [3:0] step,
                               input logic [2:0] inst, input logic [7:0] vel_in);
      int unsigned gap;
      start                <= 1'b1;
      req_op               <= op;
      req_step_index       <= step;
      req_instrument_index <= inst;
      req_velocity_in      <= vel_in;
      do @(posedge clock); while (busy);
      tracker.apply_command(op, step, inst, vel_in);
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Block idle: all responses in, then enough cycles for a clear to finish
   task automatic drain_and_pause();
      start <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_velocity();
      logic [7:0] v;
      case ($urandom_range(0, 5))
         0: v = 8'd0;
         1: v = 8'd255;
         2: v = 8'($urandom_range(128, 255));
         default: v = 8'($urandom_range(1, 127));
      endcase
      return v;
   endfunction

   function automatic logic [2:0] pick_op();
      int unsigned r;
      logic [2:0]  op;
      r = $urandom_range(0, 99);
      if (r < 35)      op = OP_SET;
      else if (r < 55) op = OP_TOGGLE;
      else if (r < 72) op = OP_READ;
      else if (r < 92) op = OP_RENDER;
      else if (r < 94) op = OP_CLEAR;
      else             op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      return op;
   endfunction

   function automatic logic [31:0] pick_swing(int phase);
      logic [31:0] v;
      case (phase)
         0: v = 32'(SWING_CEIL);
         1: v = 32'h1FF;
         2: v = 32'd0;
         3: v = 32'd1;
         4: v = $urandom_range(0, 256);
         default: v = $urandom_range(257, 511);
      endcase
      return v;
   endfunction

   // Short directed pass over the corner cases
   task automatic directed_pass();
      send_command(OP_SET,    4'd0,  3'd0, 8'd255);   // saturates to 127
      send_command(OP_READ,   4'd0,  3'd0, 8'd0);
      send_command(OP_SET,    4'd15, 3'd7, 8'd127);
      send_command(OP_SET,    4'd1,  3'd3, 8'd1);
      send_command(OP_SET,    4'd1,  3'd6, 8'd128);
      send_command(OP_TOGGLE, 4'd1,  3'd5, 8'd0);     // empty cell -> 100
      send_command(OP_RENDER, 4'd1,  3'd0, 8'd0);     // odd step, swung
      send_command(OP_TOGGLE, 4'd15, 3'd7, 8'd0);     // full cell -> 0
      send_command(OP_READ,   4'd15, 3'd7, 8'd0);
      send_command(OP_RENDER, 4'd15, 3'd0, 8'd0);     // nothing active
      send_command(OP_SET,    4'd0,  3'd0, 8'd0);     // zero velocity clears
      send_command(OP_RENDER, 4'd0,  3'd0, 8'd0);
      send_command(OP_SET,    4'd0,  3'd2, 8'd64);
      send_command(OP_RENDER, 4'd0,  3'd0, 8'd0);
      send_command(OP_READ,   4'd9,  3'd4, 8'd0);     // never written
      send_command(OP_SPARE_FIRST,        4'd0, 3'd2, 8'd255);
      send_command(OP_SPARE_FIRST + 3'd1, 4'd0, 3'd2, 8'd255);
      send_command(OP_SPARE_LAST,         4'd0, 3'd2, 8'd255);
      send_command(OP_READ,   4'd0,  3'd2, 8'd0);     // untouched by spare ops
      send_command(OP_CLEAR,  4'd0,  3'd0, 8'd0);
      send_command(OP_READ,   4'd1,  3'd3, 8'd0);
      send_command(OP_RENDER, 4'd1,  3'd0, 8'd0);
      send_command(OP_TOGGLE, 4'd14, 3'd1, 8'd0);
      send_command(OP_RENDER, 4'd14, 3'd0, 8'd0);     // even step, no swing
   endtask

   // Random phase: biased toward a few busy steps so renders carry many notes
   task automatic random_pass(int count);
      int         done;
      int         run_left;
      logic [2:0] op;
      logic [3:0] step;
      done     = 0;
      run_left = 0;
      while (done < count) begin
         if (run_left == 0) begin
            no_gaps  = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(5, 25);
         end
         run_left--;
         op   = pick_op();
         step = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
         send_command(op, step, 3'($urandom), pick_velocity());
         if (op < OP_SPARE_FIRST) done++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      start                <= 1'b0;
      req_op               <= OP_SET;
      req_step_index       <= '0;
      req_instrument_index <= '0;
      req_velocity_in      <= '0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      no_gaps               = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Register may be written while the grid is still being swept
      write_swing_reg(32'd255);
      directed_pass();

      for (int p = 0; p < PHASES; p++) begin
         drain_and_pause();
         write_swing_reg(pick_swing(p));
         random_pass(ITEMS_PER_PHASE);
      end

      drain_and_pause();
      if (tracker.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dsg_pkg.sv
rtl/dsg_grid_ram.sv
rtl/drum_step_sequencer_grid_unit.sv
rtl/dsg_checker.sv
tb/sv/drum_grid_tb_pkg.sv
tb/sv/tb_top.sv
